// File: hdl/kvt_pkg.sv
// Shared constants for the key-value table with free list.
// Request and status codes, table geometry and stream field widths.
// No dependencies.
package kvt_pkg;

    // Table geometry
    localparam int DEPTH       = 256;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int KEY_CHARS   = 8;
    localparam int VALUE_CHARS = 8;

    // Field widths
    localparam int KEY_W    = 64;
    localparam int VALUE_W  = 64;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;
    localparam int LIVE_W   = 9;

    // Stream data widths, padded to whole bytes
    localparam int IN_DATA_W  = ((KEY_W + VALUE_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((VALUE_W + LIVE_W + 7) / 8) * 8;

    // Masks that cover the allowed characters of a key and a value
    localparam logic [KEY_W-1:0] KEY_MASK =
        (KEY_CHARS >= 8) ? {KEY_W{1'b1}} : ((KEY_W'(1) << (8 * KEY_CHARS)) - KEY_W'(1));
    localparam logic [VALUE_W-1:0] VALUE_MASK =
        (VALUE_CHARS >= 8) ? {VALUE_W{1'b1}}
                           : ((VALUE_W'(1) << (8 * VALUE_CHARS)) - VALUE_W'(1));

    // Request codes
    localparam logic [REQ_W-1:0] REQ_CREATE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_BAD_FIELD = 2'd3;

endpackage

// File: hdl/key_value_table_with_free_list.sv
// Key-value table with free list: create and rejected requests pass the check state and go
// straight to the result; read, update and delete run a linear search up to the high-water
// mark that reads one slot of the key memory per cycle, then act on the matched slot.
// One request is in flight at a time; the next is taken after the result transfer.
// Reset clears the sequencer, free-list head, high-water mark and live count; the slot
// memories are not cleared, as no slot is read before it has been written.
module key_value_table_with_free_list (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // Fields from bit 0 up: key[63:0], value[127:64]
    input  logic [kvt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // Fields from bit 0 up: req_type[1:0]
    input  logic [kvt_pkg::REQ_W-1:0]      s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // Fields from bit 0 up: read_value[63:0], live_count[72:64], zero padding
    output logic [kvt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // Fields from bit 0 up: status[1:0]
    output logic [kvt_pkg::STATUS_W-1:0]   m_axis_tuser
);
    import kvt_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CHECK  = 5'b00010,
        ST_SEARCH = 5'b00100,
        ST_ACT    = 5'b01000,
        ST_RESP   = 5'b10000
    } state_t;

    // Slot memories
    logic [KEY_W-1:0]   key_mem   [DEPTH];
    logic [VALUE_W-1:0] value_mem [DEPTH];
    logic               live_mem  [DEPTH];
    logic [CNT_W-1:0]   link_mem  [DEPTH];

    // Control registers
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   free_head_reg, free_head_next;
    logic [CNT_W-1:0]   hw_reg, hw_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               cmp_busy_reg, cmp_busy_next;
    logic               cmp_end_reg, cmp_end_next;

    // Payload registers
    logic [REQ_W-1:0]    req_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [IDX_W-1:0]    cmp_idx_reg;
    logic [IDX_W-1:0]    found_reg, found_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                rv_en_reg, rv_en_next;

    // Registered memory read data
    logic [KEY_W-1:0]   key_rd_reg;
    logic               live_rd_reg;
    logic [CNT_W-1:0]   link_rd_reg;
    logic [VALUE_W-1:0] value_rd_reg;

    // Memory write controls
    logic               key_we, value_we, live_we, link_we;
    logic [IDX_W-1:0]   key_wa, value_wa, live_wa, link_wa;
    logic [VALUE_W-1:0] value_wd;
    logic               live_wd;

    // Request checks
    logic key_ok, value_ok, needs_value, in_range, hit;

    assign key_ok      = (|(key_reg & KEY_MASK)) && !(|(key_reg & ~KEY_MASK));
    assign value_ok    = (|(value_reg & VALUE_MASK)) && !(|(value_reg & ~VALUE_MASK));
    assign needs_value = (req_reg == REQ_CREATE) || (req_reg == REQ_UPDATE);
    assign in_range    = rd_idx_reg < hw_reg;
    assign hit         = cmp_busy_reg && live_rd_reg && (key_rd_reg == key_reg);

    // Stream outputs
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_RESP);
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - VALUE_W - LIVE_W){1'b0}},
                            LIVE_W'(count_reg),
                            (rv_en_reg ? value_rd_reg : {VALUE_W{1'b0}})};

    // Sequencer and table bookkeeping
    always_comb
    begin
        state_next     = state_reg;
        free_head_next = free_head_reg;
        hw_next        = hw_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_busy_next  = cmp_busy_reg;
        cmp_end_next   = cmp_end_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        rv_en_next     = rv_en_reg;
        key_we         = 1'b0;
        value_we       = 1'b0;
        live_we        = 1'b0;
        link_we        = 1'b0;
        key_wa         = found_reg;
        value_wa       = found_reg;
        live_wa        = found_reg;
        link_wa        = found_reg;
        value_wd       = value_reg;
        live_wd        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_CHECK;
                end
            end

            ST_CHECK:
            begin
                status_next  = STAT_OK;
                rv_en_next   = 1'b0;
                rd_idx_next  = '0;
                cmp_busy_next = 1'b0;
                cmp_end_next  = 1'b0;
                if (!key_ok || (needs_value && !value_ok))
                begin
                    status_next = STAT_BAD_FIELD;
                    state_next  = ST_RESP;
                end
                else if (req_reg == REQ_CREATE)
                begin
                    state_next = ST_RESP;
                    priority if (free_head_reg < hw_reg)
                    begin
                        // Reuse the most recently deleted slot.
                        found_next     = free_head_reg[IDX_W-1:0];
                        free_head_next = link_rd_reg;
                    end
                    else if (hw_reg < CNT_W'(DEPTH))
                    begin
                        // Take the next never-used slot.
                        found_next     = hw_reg[IDX_W-1:0];
                        hw_next        = hw_reg + CNT_W'(1);
                        free_head_next = hw_reg + CNT_W'(1);
                    end
                    else
                    begin
                        status_next = STAT_FULL;
                    end
                    if (status_next == STAT_OK)
                    begin
                        key_we     = 1'b1;
                        value_we   = 1'b1;
                        live_we    = 1'b1;
                        live_wd    = 1'b1;
                        key_wa     = found_next;
                        value_wa   = found_next;
                        live_wa    = found_next;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    state_next = ST_SEARCH;
                end
            end

            ST_SEARCH:
            begin
                // The compare stage trails the read address by the registered memory read.
                priority if (hit)
                begin
                    found_next = cmp_idx_reg;
                    state_next = ST_ACT;
                end
                else if (cmp_end_reg)
                begin
                    status_next = STAT_NOT_FOUND;
                    state_next  = ST_RESP;
                end
                else
                begin
                    rd_idx_next   = rd_idx_reg + CNT_W'(1);
                    cmp_busy_next = in_range;
                    cmp_end_next  = !in_range;
                end
            end

            ST_ACT:
            begin
                state_next = ST_RESP;
                unique case (req_reg)
                    REQ_READ:
                    begin
                        rv_en_next = 1'b1;
                    end
                    REQ_UPDATE:
                    begin
                        value_we = 1'b1;
                    end
                    REQ_DELETE:
                    begin
                        live_we        = 1'b1;
                        live_wd        = 1'b0;
                        link_we        = 1'b1;
                        free_head_next = CNT_W'(found_reg);
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    default:
                    begin
                        rv_en_next = 1'b0;
                    end
                endcase
            end

            ST_RESP:
            begin
                if (m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            free_head_reg <= '0;
            hw_reg        <= '0;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            cmp_busy_reg  <= 1'b0;
            cmp_end_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            hw_reg        <= hw_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_busy_reg  <= cmp_busy_next;
            cmp_end_reg   <= cmp_end_next;
        end
    end

    // Request capture and result payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            req_reg   <= s_axis_tuser;
            key_reg   <= s_axis_tdata[KEY_W-1:0];
            value_reg <= s_axis_tdata[KEY_W+VALUE_W-1:KEY_W];
        end
        cmp_idx_reg <= rd_idx_reg[IDX_W-1:0];
        found_reg   <= found_next;
        status_reg  <= status_next;
        rv_en_reg   <= rv_en_next;
    end

    // Key memory: written on create, read by the search address.
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_wa] <= key_reg;
        end
        key_rd_reg <= key_mem[rd_idx_reg[IDX_W-1:0]];
    end

    // Live flags: set on create, cleared on delete, read by the search address.
    always_ff @(posedge clk)
    begin
        if (live_we)
        begin
            live_mem[live_wa] <= live_wd;
        end
        live_rd_reg <= live_mem[rd_idx_reg[IDX_W-1:0]];
    end

    // Value memory: written on create and update, read at the matched slot.
    always_ff @(posedge clk)
    begin
        if (value_we)
        begin
            value_mem[value_wa] <= value_wd;
        end
        value_rd_reg <= value_mem[found_reg];
    end

    // Free-list links: written on delete, read at the list head.
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_wa] <= free_head_reg;
        end
        link_rd_reg <= link_mem[free_head_reg[IDX_W-1:0]];
    end

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the key-value table with free list.
// Drives request transfers with bursty gaps, stalls the result side on its own pattern,
// and checks every result against a behavioral table model. Depends on kvt_pkg and key_value_table_with_free_list.
module testbench;

    import kvt_pkg::*;

    // Slot states of the behavioral table model
    typedef enum logic [1:0] {
        SLOT_UNUSED  = 2'd0,
        SLOT_LIVE    = 2'd1,
        SLOT_DELETED = 2'd2
    } slot_state_t;

    // Result-side ready patterns
    typedef enum logic [1:0] {
        RX_ALWAYS = 2'd0,
        RX_RANDOM = 2'd1,
        RX_SPARSE = 2'd2,
        RX_LONG   = 2'd3
    } rx_mode_t;

    typedef struct {
        logic [REQ_W-1:0]   op;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } kv_request_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  read_value;
        logic [LIVE_W-1:0]   live_count;
    } kv_response_t;

    localparam int KEY_POOL_SIZE = 24;
    localparam int MIXED_ITEMS   = 1530;
    localparam int FILL_ITEMS    = 270;
    localparam int CHURN_ITEMS   = 130;
    localparam int MAX_GAP       = 300;
    localparam int MAX_STALL     = 24;

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [REQ_W-1:0]      s_axis_tuser  = REQ_CREATE;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;

    // Behavioral copy of the table
    slot_state_t        model_slot_state [DEPTH];
    logic [KEY_W-1:0]   model_key        [DEPTH];
    logic [VALUE_W-1:0] model_value      [DEPTH];
    int                 model_free_link  [DEPTH];
    int                 model_free_head;
    int                 model_high_water;
    int                 model_live_count;

    kv_request_t  request_backlog[$];
    kv_response_t expected_responses[$];
    logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];

    int       error_count = 0;
    int       status_tally [4];
    int       peak_live = 0;
    int       burst_left = 0;
    int       gap_left = 0;
    int       rx_phase = 0;
    rx_mode_t rx_mode = RX_ALWAYS;
    longint   cycle_count = 0;
    longint   cycle_limit = 64'd1000000000;
    kv_request_t  sent_request;
    kv_response_t got_response;
    kv_response_t want_response;

    key_value_table_with_free_list dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Free-running clock with a period of 4.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // A field is usable when it has some character and nothing beyond the allowed ones.
    function automatic bit field_valid(logic [63:0] x, logic [63:0] mask);
        return ((x & mask) != '0) && ((x & ~mask) == '0);
    endfunction

    // Applies one request to the table model and returns the result it should give.
    function automatic kv_response_t apply_table_request(kv_request_t rq);
        kv_response_t rsp;
        int slot;
        int i;
        rsp.status     = STAT_OK;
        rsp.read_value = '0;
        slot = DEPTH;
        if (!field_valid(rq.key, KEY_MASK) ||
            ((rq.op == REQ_CREATE || rq.op == REQ_UPDATE) && !field_valid(rq.value, VALUE_MASK)))
        begin
            rsp.status = STAT_BAD_FIELD;
        end
        else if (rq.op == REQ_CREATE)
        begin
            // Reuse a deleted slot first, then take a fresh one.
            if (model_free_head < model_high_water)
            begin
                slot = model_free_head;
                model_free_head = model_free_link[slot];
            end
            else if (model_high_water < DEPTH)
            begin
                slot = model_high_water;
                model_high_water++;
                model_free_head = model_high_water;
            end
            else
            begin
                rsp.status = STAT_FULL;
            end
            if (slot < DEPTH)
            begin
                model_slot_state[slot] = SLOT_LIVE;
                model_key[slot]        = rq.key;
                model_value[slot]      = rq.value;
                model_live_count++;
            end
        end
        else
        begin
            // Lowest live slot with a matching key wins.
            for (i = 0; i < model_high_water && slot == DEPTH; i++)
            begin
                if (model_slot_state[i] == SLOT_LIVE && model_key[i] == rq.key)
                    slot = i;
            end
            if (slot >= DEPTH)
                rsp.status = STAT_NOT_FOUND;
            else if (rq.op == REQ_READ)
                rsp.read_value = model_value[slot];
            else if (rq.op == REQ_UPDATE)
                model_value[slot] = rq.value;
            else
            begin
                model_slot_state[slot] = SLOT_DELETED;
                model_free_link[slot]  = model_free_head;
                model_free_head        = slot;
                if (model_live_count > 0)
                    model_live_count--;
            end
        end
        rsp.live_count = LIVE_W'(model_live_count);
        return rsp;
    endfunction

    task automatic queue_request(logic [REQ_W-1:0] op, logic [KEY_W-1:0] key,
                                 logic [VALUE_W-1:0] value);
        kv_request_t rq;
        rq.op    = op;
        rq.key   = key;
        rq.value = value;
        request_backlog.push_back(rq);
    endtask

    // Request driver: bursts of transfers separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= REQ_CREATE;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                sent_request = request_backlog.pop_front();
                expected_responses.push_back(apply_table_request(sent_request));
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 5);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: gap_left = $urandom_range(0, 3);
                        6, 7, 8:          gap_left = $urandom_range(4, 24);
                        default:          gap_left = $urandom_range(25, MAX_GAP);
                    endcase
                end
                if (gap_left > 0 || request_backlog.size() == 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
                else
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= IN_DATA_W'({request_backlog[0].value,
                                                 request_backlog[0].key});
                    s_axis_tuser  <= request_backlog[0].op;
                end
            end
            else if (!s_axis_tvalid)
            begin
                // Idle: count down the gap, then present the next request.
                if (gap_left > 0)
                    gap_left--;
                else if (request_backlog.size() != 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= IN_DATA_W'({request_backlog[0].value,
                                                 request_backlog[0].key});
                    s_axis_tuser  <= request_backlog[0].op;
                end
            end
        end
    end

    // Result monitor and ready pattern of the receiving side.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_phase = 0;
            rx_mode  = RX_ALWAYS;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_response.status     = m_axis_tuser;
                got_response.read_value = m_axis_tdata[VALUE_W-1:0];
                got_response.live_count = m_axis_tdata[VALUE_W +: LIVE_W];
                status_tally[got_response.status]++;
                if (int'(got_response.live_count) > peak_live)
                    peak_live = int'(got_response.live_count);
                if (expected_responses.size() == 0)
                begin
                    $display("%0t: result transfer with none outstanding: status %0d value %h count %0d",
                             $time, got_response.status, got_response.read_value,
                             got_response.live_count);
                    error_count++;
                end
                else
                begin
                    want_response = expected_responses.pop_front();
                    if (got_response.status !== want_response.status)
                    begin
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $time, want_response.status, got_response.status);
                        error_count++;
                    end
                    if (got_response.read_value !== want_response.read_value)
                    begin
                        $display("%0t: read_value mismatch: expected %h actual %h",
                                 $time, want_response.read_value, got_response.read_value);
                        error_count++;
                    end
                    if (got_response.live_count !== want_response.live_count)
                    begin
                        $display("%0t: live_count mismatch: expected %0d actual %0d",
                                 $time, want_response.live_count, got_response.live_count);
                        error_count++;
                    end
                end
            end

            // Switch the stall pattern every so often.
            rx_phase++;
            if (rx_phase % 97 == 0)
                rx_mode = rx_mode_t'($urandom_range(0, 3));
            case (rx_mode)
                RX_ALWAYS: m_axis_tready <= 1'b1;
                RX_RANDOM: m_axis_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_axis_tready <= (rx_phase % 5) == 0;
                default:   m_axis_tready <= (rx_phase % 23) >= 16;
            endcase
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > cycle_limit)
        begin
            $display("key_value_table_with_free_list verification failed");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        logic [KEY_W-1:0]   k1;
        logic [KEY_W-1:0]   k2;
        logic [KEY_W-1:0]   pick_key;
        logic [VALUE_W-1:0] pick_value;
        int roll;
        int i;

        for (i = 0; i < DEPTH; i++)
        begin
            model_slot_state[i] = SLOT_UNUSED;
            model_key[i]        = '0;
            model_value[i]      = '0;
            model_free_link[i]  = 0;
        end
        model_free_head  = 0;
        model_high_water = 0;
        model_live_count = 0;
        for (i = 0; i < 4; i++)
            status_tally[i] = 0;

        // Key pool: a few fixed patterns, the rest random.
        key_pool[0] = '1;
        key_pool[1] = 64'h1;
        key_pool[2] = 64'h8000_0000_0000_0000;
        key_pool[3] = 64'h4847_4645_4443_4241;
        for (i = 4; i < KEY_POOL_SIZE; i++)
        begin
            key_pool[i] = rand64();
            if (key_pool[i] == '0)
                key_pool[i] = 64'h5a;
        end

        // Directed part: rejected fields, duplicates, misses and free-list reuse.
        k1 = 64'h4847_4645_4443_4241;
        k2 = '1;
        queue_request(REQ_READ,   k1, '0);
        queue_request(REQ_CREATE, '0, 64'h1234);
        queue_request(REQ_CREATE, k1, '0);
        queue_request(REQ_READ,   '0, '1);
        queue_request(REQ_UPDATE, '0, 64'h77);
        queue_request(REQ_DELETE, '0, '0);
        queue_request(REQ_CREATE, k1, '1);
        queue_request(REQ_CREATE, k1, 64'h1);
        queue_request(REQ_READ,   k1, '0);
        queue_request(REQ_UPDATE, k1, 64'h8000_0000_0000_0000);
        queue_request(REQ_UPDATE, k1, '0);
        queue_request(REQ_READ,   k1, 64'hdead_beef_0bad_f00d);
        queue_request(REQ_DELETE, k1, '1);
        queue_request(REQ_READ,   k1, '0);
        queue_request(REQ_CREATE, k2, 64'h0123_4567_89ab_cdef);
        queue_request(REQ_READ,   k2, '0);
        queue_request(REQ_DELETE, k1, '0);
        queue_request(REQ_DELETE, k1, '0);
        queue_request(REQ_UPDATE, 64'h1, 64'h55);
        queue_request(REQ_CREATE, 64'h1, 64'hfedc_ba98_7654_3210);
        queue_request(REQ_DELETE, k2, '0);
        queue_request(REQ_DELETE, 64'h1, '0);
        queue_request(REQ_CREATE, 64'h8000_0000_0000_0000, 64'h2);
        queue_request(REQ_CREATE, 64'h42, 64'h3);
        queue_request(REQ_CREATE, 64'h43, 64'h4);

        // Mixed traffic on a small key pool, with some noise.
        for (i = 0; i < MIXED_ITEMS; i++)
        begin
            roll = $urandom_range(0, 99);
            pick_key = ($urandom_range(0, 9) == 0) ? rand64()
                                                   : key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
            pick_value = rand64();
            if (roll < 3)
                queue_request(REQ_W'($urandom_range(0, 3)), '0, pick_value);
            else if (roll < 6)
                queue_request(($urandom_range(0, 1) == 0) ? REQ_CREATE : REQ_UPDATE, pick_key, '0);
            else if (pick_value == '0)
                queue_request(REQ_READ, pick_key, pick_value);
            else if (roll < 34)
                queue_request(REQ_CREATE, pick_key, pick_value);
            else if (roll < 58)
                queue_request(REQ_READ, pick_key, pick_value);
            else if (roll < 72)
                queue_request(REQ_UPDATE, pick_key, pick_value);
            else
                queue_request(REQ_DELETE, pick_key, pick_value);
        end

        // Fill the table until creates come back full.
        for (i = 0; i < FILL_ITEMS; i++)
        begin
            pick_key = ($urandom_range(0, 1) == 0) ? rand64()
                                                   : key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
            pick_value = rand64();
            if (pick_key == '0)
                pick_key = 64'h99;
            if (pick_value == '0)
                pick_value = 64'h1;
            queue_request(REQ_CREATE, pick_key, pick_value);
        end

        // Churn on a full table: deletes open slots that creates take again.
        for (i = 0; i < CHURN_ITEMS; i++)
        begin
            roll = $urandom_range(0, 99);
            pick_key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
            pick_value = rand64();
            if (pick_value == '0)
                pick_value = 64'h1;
            if (roll < 40)
                queue_request(REQ_CREATE, pick_key, pick_value);
            else if (roll < 65)
                queue_request(REQ_DELETE, pick_key, pick_value);
            else if (roll < 85)
                queue_request(REQ_READ, pick_key, pick_value);
            else
                queue_request(REQ_UPDATE, pick_key, pick_value);
        end

        // Slowest run: every item waits out a full search, a long gap and long stalls.
        cycle_limit = longint'(request_backlog.size()) * (DEPTH + 8 + MAX_GAP + MAX_STALL) * 3
                      + 1000;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (request_backlog.size() != 0 || expected_responses.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 8) @(posedge clk);

        $display("Ran %0d requests: %0d ok, %0d not found, %0d full, %0d rejected fields.",
                 status_tally[0] + status_tally[1] + status_tally[2] + status_tally[3],
                 status_tally[STAT_OK], status_tally[STAT_NOT_FOUND],
                 status_tally[STAT_FULL], status_tally[STAT_BAD_FIELD]);
        $display("Peak live count %0d, final high-water mark %0d.", peak_live, model_high_water);
        if (error_count == 0)
            $display("key_value_table_with_free_list verification clean");
        else
            $display("key_value_table_with_free_list verification failed");
        $finish;
    end

endmodule
